/* hw/rtl/bilinear_image_scaler_defines.svh */
// ----------------------------------------------------------------------------
// bilinear image scaler assertion macros
// shared property wrappers, clocked on clock and disabled in reset
// ----------------------------------------------------------------------------
`ifndef BILINEAR_IMAGE_SCALER_DEFINES_SVH
`define BILINEAR_IMAGE_SCALER_DEFINES_SVH

// same-cycle implication
`define BIS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BIS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/bis_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_pkg
// shared types and constants of the bilinear image scaler
// ----------------------------------------------------------------------------
package bis_pkg;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   localparam int POS_W            = 30;   // output index times step
   localparam int OUT_DIM_W        = 14;
   localparam int SRC_DIM_W        = 12;
   localparam int SRC_HEIGHT_LIMIT = 2048;
   localparam int OUT_DIM_LIMIT    = 8192;
   localparam int SIDE_CAP         = 8;
   localparam int SIDE_W           = 4;

   localparam logic [2:0] REG_SOURCE_WIDTH  = 3'd0;
   localparam logic [2:0] REG_SOURCE_HEIGHT = 3'd1;
   localparam logic [2:0] REG_OUTPUT_WIDTH  = 3'd2;
   localparam logic [2:0] REG_OUTPUT_HEIGHT = 3'd3;
   localparam logic [2:0] REG_SOURCE_STEP   = 3'd4;

endpackage

/* hw/rtl/bis_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_req_if
// source pixel channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface bis_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_red;
   logic [7:0] in_green;
   logic [7:0] in_blue;

   modport source (output valid, in_red, in_green, in_blue, input ready);
   modport sink   (input valid, in_red, in_green, in_blue, output ready);
endinterface

/* hw/rtl/bis_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_rsp_if
// scaled pixel channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface bis_rsp_if;
   logic        valid;
   logic        ready;
   logic [12:0] out_row;
   logic [12:0] out_col;
   logic [7:0]  out_red;
   logic [7:0]  out_green;
   logic [7:0]  out_blue;
   logic        run_last;

   modport source (output valid, out_row, out_col, out_red, out_green, out_blue, run_last,
                   input ready);
   modport sink   (input valid, out_row, out_col, out_red, out_green, out_blue, run_last,
                   output ready);
endinterface

/* hw/rtl/bis_blend.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_blend
// two-step bilinear weighting: horizontal sums registered, vertical blend after
// ----------------------------------------------------------------------------
module bis_blend #(
   parameter int FRACTION_BITS = 12
) (
   input  logic                     clock,
   input  logic                     load,
   input  bis_pkg::pixel_type       p00,
   input  bis_pkg::pixel_type       p01,
   input  bis_pkg::pixel_type       p10,
   input  bis_pkg::pixel_type       p11,
   input  logic [FRACTION_BITS-1:0] u,
   input  logic [FRACTION_BITS-1:0] v,
   output bis_pkg::pixel_type       result
);
   localparam int WT_W  = FRACTION_BITS + 1;
   localparam int TOP_W = 8 + FRACTION_BITS;
   localparam int ACC_W = 8 + 2 * FRACTION_BITS;
   localparam logic [WT_W-1:0] ONE = WT_W'(1) << FRACTION_BITS;

   logic [2:0][7:0]       a00, a01, a10, a11, res;
   logic [WT_W-1:0]       sv, su, v_x, u_x;
   logic [2:0][TOP_W-1:0] top_ff, bot_ff;
   logic [WT_W-1:0]       u_ff;
   logic [2:0][ACC_W:0]   acc;

   assign a00 = p00;
   assign a01 = p01;
   assign a10 = p10;
   assign a11 = p11;
   assign v_x = WT_W'(v);
   assign u_x = WT_W'(u);
   assign sv  = ONE - v_x;
   assign su  = ONE - u_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         for (int k = 0; k < 3; k++) begin
            top_ff[k] <= TOP_W'(TOP_W'(a00[k] * sv) + TOP_W'(a01[k] * v_x));
            bot_ff[k] <= TOP_W'(TOP_W'(a10[k] * sv) + TOP_W'(a11[k] * v_x));
         end
         u_ff <= u_x;
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         acc[k] = (ACC_W+1)'(top_ff[k] * su) + (ACC_W+1)'(bot_ff[k] * u_ff);
         res[k] = acc[k][2*FRACTION_BITS +: 8];
      end
   end

   assign result = res;
endmodule

/* hw/rtl/bilinear_image_scaler.sv */
`timescale 1ns / 1ps
// one source pixel at a time: req_chan.ready is high only in IDLE, after the last pixel is done
// each result passes EMIT_A and EMIT_B; EMIT_A waits while the result register is still full
// a single sequencer shares one position multiplier between the column and row scans
// the line store is read and written once per pixel, read before write on its one port
// reset: synchronous, clears counters, state, left/upper-left pixels; line store is not cleared
// ----------------------------------------------------------------------------
// bilinear_image_scaler
// raster-order RGB bilinear scaler with a one-row line store
// ----------------------------------------------------------------------------
`include "bilinear_image_scaler_defines.svh"

module bilinear_image_scaler #(
   parameter int MAX_SOURCE_WIDTH = 2048,
   parameter int FRACTION_BITS    = 12
) (
   input  logic        clock,
   input  logic        reset,
   bis_req_if.sink     req_chan,
   bis_rsp_if.source   rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   localparam int AW    = (MAX_SOURCE_WIDTH > 1) ? $clog2(MAX_SOURCE_WIDTH) : 1;
   localparam int WW    = $clog2(MAX_SOURCE_WIDTH + 1);
   localparam int PW    = bis_pkg::POS_W;
   localparam int DW    = bis_pkg::OUT_DIM_W;
   localparam int FL_W  = PW - FRACTION_BITS;
   localparam int LIM_W = FL_W + 1;
   localparam int SW    = bis_pkg::SIDE_W;
   localparam logic [15:0] STEP_MIN = 16'((1 << FRACTION_BITS) >> 2);

   typedef enum logic [3:0] {
      IDLE, MUL_C, SCAN_C, MUL_R, SCAN_R, SETUP, EMIT_A, EMIT_B, FINISH
   } state_type;

   // configuration registers
   logic [11:0] cfg_sw_ff, cfg_sh_ff;
   logic [13:0] cfg_ow_ff, cfg_oh_ff;
   logic [15:0] cfg_step_ff;
   logic        cfg_wr;

   assign pready = 1'b1;
   assign cfg_wr = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_sw_ff   <= 12'd640;
         cfg_sh_ff   <= 12'd480;
         cfg_ow_ff   <= 14'd640;
         cfg_oh_ff   <= 14'd480;
         cfg_step_ff <= 16'd4096;
      end else if (cfg_wr) begin
         case (paddr[4:2])
            bis_pkg::REG_SOURCE_WIDTH:  cfg_sw_ff   <= pwdata[11:0];
            bis_pkg::REG_SOURCE_HEIGHT: cfg_sh_ff   <= pwdata[11:0];
            bis_pkg::REG_OUTPUT_WIDTH:  cfg_ow_ff   <= pwdata[13:0];
            bis_pkg::REG_OUTPUT_HEIGHT: cfg_oh_ff   <= pwdata[13:0];
            bis_pkg::REG_SOURCE_STEP:   cfg_step_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         bis_pkg::REG_SOURCE_WIDTH:  prdata = 32'(cfg_sw_ff);
         bis_pkg::REG_SOURCE_HEIGHT: prdata = 32'(cfg_sh_ff);
         bis_pkg::REG_OUTPUT_WIDTH:  prdata = 32'(cfg_ow_ff);
         bis_pkg::REG_OUTPUT_HEIGHT: prdata = 32'(cfg_oh_ff);
         bis_pkg::REG_SOURCE_STEP:   prdata = 32'(cfg_step_ff);
         default:                    prdata = 32'd0;
      endcase
   end

   // saturated working values
   logic [13:0] sw_x;
   logic [WW-1:0] w_eff;
   logic [11:0] h_eff;
   logic [DW-1:0] ow_eff, oh_eff;
   logic [15:0] step_eff;

   assign sw_x     = 14'(cfg_sw_ff);
   assign w_eff    = (sw_x == 14'd0) ? WW'(1) :
                     (sw_x > 14'(MAX_SOURCE_WIDTH)) ? WW'(MAX_SOURCE_WIDTH) : WW'(sw_x);
   assign h_eff    = (cfg_sh_ff == 12'd0) ? 12'd1 :
                     (cfg_sh_ff > 12'(bis_pkg::SRC_HEIGHT_LIMIT)) ?
                        12'(bis_pkg::SRC_HEIGHT_LIMIT) : cfg_sh_ff;
   assign ow_eff   = (cfg_ow_ff == 14'd0) ? 14'd1 :
                     (cfg_ow_ff > 14'(bis_pkg::OUT_DIM_LIMIT)) ?
                        14'(bis_pkg::OUT_DIM_LIMIT) : cfg_ow_ff;
   assign oh_eff   = (cfg_oh_ff == 14'd0) ? 14'd1 :
                     (cfg_oh_ff > 14'(bis_pkg::OUT_DIM_LIMIT)) ?
                        14'(bis_pkg::OUT_DIM_LIMIT) : cfg_oh_ff;
   assign step_eff = (cfg_step_ff < STEP_MIN) ? STEP_MIN : cfg_step_ff;

   // line store, read-first on its single port
   bis_pkg::pixel_type row_store [MAX_SOURCE_WIDTH];
   bis_pkg::pixel_type above_ff;
   logic [AW-1:0]      sc_ff;
   logic               req_take;
   bis_pkg::pixel_type req_pix;

   assign req_pix.red   = req_chan.in_red;
   assign req_pix.green = req_chan.in_green;
   assign req_pix.blue  = req_chan.in_blue;

   always_ff @(posedge clock) begin
      if (req_take) begin
         above_ff          <= row_store[sc_ff];
         row_store[sc_ff]  <= req_pix;
      end
   end

   // sequencer state
   state_type          state_ff;
   bis_pkg::pixel_type cur_ff, left_ff, ul_ff;
   logic [10:0]        sr_ff;
   logic [DW-1:0]      nc_ff, nr_ff, col_end_ff, row_end_ff;
   logic [PW-1:0]      pos_ff, pos_c0_ff, pos_r0_ff, pos_c_ff, pos_r_ff;
   logic [SW-1:0]      ncols_ff, nrows_ff, ci_ff, ri_ff;
   logic [12:0]        orow_ff, ocol_ff;
   logic               olast_ff;
   logic               rsp_valid_ff;
   logic [12:0]        rsp_row_ff, rsp_col_ff;
   logic               rsp_last_ff;
   bis_pkg::pixel_type rsp_pix_ff;

   assign req_take       = req_chan.valid & req_chan.ready;
   assign req_chan.ready = (state_ff == IDLE);

   // position multiplier and scan compare
   logic [DW-1:0]    mul_a;
   logic [PW-1:0]    mul_p;
   logic             scan_c;
   logic [LIM_W-1:0] scan_fl1, scan_lim, scan_cnt;
   logic             scan_hit, scan_clamp;
   logic [DW-1:0]    scan_end, scan_end_lim;

   assign mul_a        = (state_ff == MUL_C) ? nc_ff : nr_ff;
   assign mul_p        = PW'(mul_a * step_eff);
   assign scan_c       = (state_ff == SCAN_C);
   assign scan_fl1     = LIM_W'(pos_ff[PW-1:FRACTION_BITS]) + LIM_W'(1);
   assign scan_lim     = scan_c ? LIM_W'(w_eff) : LIM_W'(h_eff);
   assign scan_cnt     = scan_c ? LIM_W'(sc_ff) : LIM_W'(sr_ff);
   assign scan_clamp   = (scan_fl1 >= scan_lim);
   assign scan_hit     = scan_clamp ? (scan_lim - LIM_W'(1) <= scan_cnt) : (scan_fl1 <= scan_cnt);
   assign scan_end     = scan_c ? col_end_ff : row_end_ff;
   assign scan_end_lim = scan_c ? ow_eff : oh_eff;

   // neighbor selection for the current output
   logic [LIM_W-1:0]   fl_c, fl_r, wm1, hm1, sc_x, sr_x;
   logic               left_cur, top_cur;
   bis_pkg::pixel_type p00, p01, p10, blended;
   logic               out_free, emit_load;
   logic [DW-1:0]      row_span, col_span;

   assign fl_c     = LIM_W'(pos_c_ff[PW-1:FRACTION_BITS]);
   assign fl_r     = LIM_W'(pos_r_ff[PW-1:FRACTION_BITS]);
   assign wm1      = LIM_W'(w_eff) - LIM_W'(1);
   assign hm1      = LIM_W'(h_eff) - LIM_W'(1);
   assign sc_x     = LIM_W'(sc_ff);
   assign sr_x     = LIM_W'(sr_ff);
   assign left_cur = (fl_c >= wm1) ? (wm1 >= sc_x) : (fl_c >= sc_x);
   assign top_cur  = (fl_r >= hm1) ? (hm1 >= sr_x) : (fl_r >= sr_x);
   assign p10      = left_cur ? cur_ff : left_ff;
   assign p01      = top_cur ? cur_ff : above_ff;
   assign p00      = top_cur ? p10 : (left_cur ? above_ff : ul_ff);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign emit_load = (state_ff == EMIT_A) && out_free;
   assign row_span = row_end_ff - nr_ff;
   assign col_span = col_end_ff - nc_ff;

   bis_blend #(.FRACTION_BITS(FRACTION_BITS)) u_blend (
      .clock  (clock),
      .load   (emit_load),
      .p00    (p00),
      .p01    (p01),
      .p10    (p10),
      .p11    (cur_ff),
      .u      (pos_r_ff[FRACTION_BITS-1:0]),
      .v      (pos_c_ff[FRACTION_BITS-1:0]),
      .result (blended)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         left_ff      <= '0;
         ul_ff        <= '0;
         sc_ff        <= '0;
         sr_ff        <= '0;
         nc_ff        <= '0;
         nr_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         ci_ff        <= '0;
         ri_ff        <= '0;
         ncols_ff     <= '0;
         nrows_ff     <= '0;
      end else begin
         if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            IDLE: begin
               if (req_take) begin
                  cur_ff   <= req_pix;
                  state_ff <= MUL_C;
               end
            end
            MUL_C: begin
               pos_ff     <= mul_p;
               pos_c0_ff  <= mul_p;
               col_end_ff <= nc_ff;
               state_ff   <= SCAN_C;
            end
            MUL_R: begin
               pos_ff     <= mul_p;
               pos_r0_ff  <= mul_p;
               row_end_ff <= nr_ff;
               state_ff   <= SCAN_R;
            end
            SCAN_C, SCAN_R: begin
               if (scan_end >= scan_end_lim || !scan_hit) begin
                  state_ff <= scan_c ? MUL_R : SETUP;
               end else if (scan_clamp) begin
                  // every later index hits too once the neighbor clamps at the edge
                  if (scan_c) col_end_ff <= scan_end_lim;
                  else        row_end_ff <= scan_end_lim;
                  state_ff <= scan_c ? MUL_R : SETUP;
               end else begin
                  if (scan_c) col_end_ff <= col_end_ff + DW'(1);
                  else        row_end_ff <= row_end_ff + DW'(1);
                  pos_ff <= pos_ff + PW'(step_eff);
               end
            end
            SETUP: begin
               nrows_ff <= (row_span > DW'(bis_pkg::SIDE_CAP)) ?
                           SW'(bis_pkg::SIDE_CAP) : SW'(row_span);
               ncols_ff <= (col_span > DW'(bis_pkg::SIDE_CAP)) ?
                           SW'(bis_pkg::SIDE_CAP) : SW'(col_span);
               ri_ff    <= '0;
               ci_ff    <= '0;
               pos_r_ff <= pos_r0_ff;
               pos_c_ff <= pos_c0_ff;
               state_ff <= (row_span == '0 || col_span == '0) ? FINISH : EMIT_A;
            end
            EMIT_A: begin
               if (out_free) begin
                  orow_ff  <= 13'(nr_ff + DW'(ri_ff));
                  ocol_ff  <= 13'(nc_ff + DW'(ci_ff));
                  olast_ff <= (ri_ff == nrows_ff - SW'(1)) && (ci_ff == ncols_ff - SW'(1));
                  state_ff <= EMIT_B;
               end
            end
            EMIT_B: begin
               rsp_valid_ff <= 1'b1;
               rsp_row_ff   <= orow_ff;
               rsp_col_ff   <= ocol_ff;
               rsp_last_ff  <= olast_ff;
               rsp_pix_ff   <= blended;
               if (ci_ff == ncols_ff - SW'(1)) begin
                  ci_ff    <= '0;
                  pos_c_ff <= pos_c0_ff;
                  ri_ff    <= ri_ff + SW'(1);
                  pos_r_ff <= pos_r_ff + PW'(step_eff);
                  state_ff <= (ri_ff == nrows_ff - SW'(1)) ? FINISH : EMIT_A;
               end else begin
                  ci_ff    <= ci_ff + SW'(1);
                  pos_c_ff <= pos_c_ff + PW'(step_eff);
                  state_ff <= EMIT_A;
               end
            end
            FINISH: begin
               ul_ff   <= above_ff;
               left_ff <= cur_ff;
               nc_ff   <= col_end_ff;
               if (WW'(sc_ff) + WW'(1) >= w_eff) begin
                  sc_ff <= '0;
                  nc_ff <= '0;
                  if (12'(sr_ff) + 12'd1 >= h_eff) begin
                     sr_ff <= '0;
                     nr_ff <= '0;
                  end else begin
                     sr_ff <= sr_ff + 11'd1;
                     nr_ff <= row_end_ff;
                  end
               end else begin
                  sc_ff <= sc_ff + AW'(1);
               end
               state_ff <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_row   = rsp_row_ff;
   assign rsp_chan.out_col   = rsp_col_ff;
   assign rsp_chan.out_red   = rsp_pix_ff.red;
   assign rsp_chan.out_green = rsp_pix_ff.green;
   assign rsp_chan.out_blue  = rsp_pix_ff.blue;
   assign rsp_chan.run_last  = rsp_last_ff;

   `BIS_ASSERT_NOW(a_emit_index_range, (state_ff == EMIT_A || state_ff == EMIT_B), (ci_ff < ncols_ff && ri_ff < nrows_ff), "emission index past its span")
   `BIS_ASSERT_NEXT(a_last_ends_pixel, (state_ff == EMIT_B && olast_ff), (state_ff == FINISH && rsp_valid_ff && rsp_last_ff), "last result did not close the pixel")
   `BIS_ASSERT_NOW(a_result_from_emit, $rose(rsp_valid_ff), $past(state_ff == EMIT_B), "result raised outside the emit step")
   `BIS_ASSERT_NEXT(a_take_starts_work, req_take, (state_ff == MUL_C), "accepted pixel did not start processing")

endmodule

/* tb/sv/bis_scaler_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_scaler_checker
// watches the source pixel, scaled pixel and register channels, predicts every
// scaled pixel from the source stream and compares each result field by field
// ----------------------------------------------------------------------------
module bis_scaler_checker (
   input  logic        clock,
   input  logic        reset,
   bis_req_if          req,
   bis_rsp_if          rsp,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          fail_count,
   output int          pending
);

   localparam int LINE_DEPTH = 2048;
   localparam int FRAC       = 12;

   typedef struct {
      logic [12:0] row;
      logic [12:0] col;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic        last;
   } scaled_pixel_type;

   scaled_pixel_type expected_pixels[$];

   logic [23:0] line_mem [LINE_DEPTH];
   logic [23:0] left_px, upper_left_px;
   int unsigned src_row, src_col, out_row_next, out_col_next;
   logic [11:0] cfg_src_w, cfg_src_h;
   logic [13:0] cfg_out_w, cfg_out_h;
   logic [15:0] cfg_step;

   assign pending = expected_pixels.size();

   function automatic int unsigned clamp_u(int unsigned v, int unsigned lo, int unsigned hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // integer source coordinate of an output index, clamped to the last source index
   function automatic int unsigned source_index(int unsigned idx, int unsigned step,
                                                int unsigned lim, int unsigned add);
      longint unsigned f;
      f = ((longint'(idx) * step) >> FRAC) + add;
      return (f >= lim) ? lim - 1 : int'(f);
   endfunction

   function automatic int unsigned fraction_of(int unsigned idx, int unsigned step);
      return int'((longint'(idx) * step) & ((1 << FRAC) - 1));
   endfunction

   function automatic logic [7:0] blend_chan(logic [7:0] p00, logic [7:0] p01,
                                             logic [7:0] p10, logic [7:0] p11,
                                             int unsigned u, int unsigned v);
      longint unsigned s;
      longint unsigned acc;
      s = 1 << FRAC;
      acc = longint'(p00) * (s - u) * (s - v) + longint'(p01) * (s - u) * v
          + longint'(p10) * u * (s - v) + longint'(p11) * u * v;
      return acc[2*FRAC +: 8];
   endfunction

   task automatic predict_scaled(logic [23:0] cur);
      int unsigned w, h, ow, oh, step, sr, sc, col_end, row_end, u, v;
      logic [23:0] above, p00, p01, p10;
      logic top_cur, left_cur;
      scaled_pixel_type sp;
      int produced;
      w = clamp_u(cfg_src_w, 1, LINE_DEPTH);
      h = clamp_u(cfg_src_h, 1, bis_pkg::SRC_HEIGHT_LIMIT);
      ow = clamp_u(cfg_out_w, 1, bis_pkg::OUT_DIM_LIMIT);
      oh = clamp_u(cfg_out_h, 1, bis_pkg::OUT_DIM_LIMIT);
      step = clamp_u(cfg_step, (1 << FRAC) >> 2, 32'hFFFF_FFFF);
      sr = src_row;
      sc = src_col;
      produced = 0;
      above = line_mem[sc];
      line_mem[sc] = cur;
      col_end = out_col_next;
      while (col_end < ow && source_index(col_end, step, w, 1) <= sc) col_end++;
      row_end = out_row_next;
      while (row_end < oh && source_index(row_end, step, h, 1) <= sr) row_end++;
      // at most 8 by 8 results per pixel, the rest are dropped
      for (int unsigned r = out_row_next; r < row_end && r - out_row_next < bis_pkg::SIDE_CAP;
           r++) begin
         top_cur = source_index(r, step, h, 0) >= sr;
         u = fraction_of(r, step);
         for (int unsigned c = out_col_next;
              c < col_end && c - out_col_next < bis_pkg::SIDE_CAP; c++) begin
            left_cur = source_index(c, step, w, 0) >= sc;
            v = fraction_of(c, step);
            p10 = left_cur ? cur : left_px;
            p01 = top_cur ? cur : above;
            p00 = top_cur ? p10 : (left_cur ? above : upper_left_px);
            sp.row = r[12:0];
            sp.col = c[12:0];
            sp.red = blend_chan(p00[23:16], p01[23:16], p10[23:16], cur[23:16], u, v);
            sp.green = blend_chan(p00[15:8], p01[15:8], p10[15:8], cur[15:8], u, v);
            sp.blue = blend_chan(p00[7:0], p01[7:0], p10[7:0], cur[7:0], u, v);
            sp.last = 1'b0;
            expected_pixels.push_back(sp);
            produced++;
         end
      end
      if (produced > 0) expected_pixels[$].last = 1'b1;
      upper_left_px = above;
      left_px = cur;
      out_col_next = col_end;
      if (sc + 1 >= w) begin
         src_col = 0;
         out_col_next = 0;
         if (sr + 1 >= h) begin
            src_row = 0;
            out_row_next = 0;
         end else begin
            src_row = sr + 1;
            out_row_next = row_end;
         end
      end else begin
         src_col = sc + 1;
      end
   endtask

   task automatic compare_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
         $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_val, act_val);
         fail_count++;
      end
   endtask

   initial begin
      fail_count = 0;
      for (int i = 0; i < LINE_DEPTH; i++) line_mem[i] = '0;
   end

   always @(posedge clock) begin
      scaled_pixel_type sp;
      if (reset) begin
         left_px = '0;
         upper_left_px = '0;
         src_row = 0;
         src_col = 0;
         out_row_next = 0;
         out_col_next = 0;
         cfg_src_w = 12'd640;
         cfg_src_h = 12'd480;
         cfg_out_w = 14'd640;
         cfg_out_h = 14'd480;
         cfg_step = 16'd4096;
         expected_pixels.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
               bis_pkg::REG_SOURCE_WIDTH:  cfg_src_w = pwdata[11:0];
               bis_pkg::REG_SOURCE_HEIGHT: cfg_src_h = pwdata[11:0];
               bis_pkg::REG_OUTPUT_WIDTH:  cfg_out_w = pwdata[13:0];
               bis_pkg::REG_OUTPUT_HEIGHT: cfg_out_h = pwdata[13:0];
               bis_pkg::REG_SOURCE_STEP:   cfg_step = pwdata[15:0];
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t unexpected result row %0d col %0d", $time, rsp.out_row,
                        rsp.out_col);
               fail_count++;
            end else begin
               sp = expected_pixels.pop_front();
               compare_field("out_row", sp.row, rsp.out_row);
               compare_field("out_col", sp.col, rsp.out_col);
               compare_field("out_red", sp.red, rsp.out_red);
               compare_field("out_green", sp.green, rsp.out_green);
               compare_field("out_blue", sp.blue, rsp.out_blue);
               compare_field("run_last", sp.last, rsp.run_last);
            end
         end
         // a result and a source transaction in the same cycle never depend on each other
         if (req.valid && req.ready)
            predict_scaled({req.in_red, req.in_green, req.in_blue});
      end
   end

endmodule

/* tb/sv/tb_bilinear_image_scaler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bilinear_image_scaler
// streams whole source frames through the scaler under several scale settings,
// with random gaps and stalls on both channels; the checker judges each result
// ----------------------------------------------------------------------------
module tb_bilinear_image_scaler;

   localparam int IDLE_LIMIT  = 100000;
   localparam int TARGET_PIX  = 210;
   localparam int LONG_STALL  = 400;

   logic        clock;
   logic        reset;
   logic        psel, penable, pwrite;
   logic [4:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;
   int          fail_count, pending;
   int          src_idle_pct, rsp_idle_pct;
   int          pixels_sent;
   bit          stall_request;
   int          hold_cycles;

   // directed pixels of the first frame: black, white, walking ones and zeros
   logic [23:0] sw_list [12] = '{24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF,
                                 24'h010204, 24'h081020, 24'h408000, 24'hFEFDFB,
                                 24'hF7EFDF, 24'hBF7FFF, 24'hFFFFFF, 24'h000000};

   bis_req_if req_chan ();
   bis_rsp_if rsp_chan ();

   bilinear_image_scaler DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   bis_scaler_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .rsp        (rsp_chan),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .pready     (pready),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // receiver: random back-pressure, plus one long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_request) begin
            stall_request = 0;
            stall_left = LONG_STALL;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // watchdog on cycles without any transaction
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // only between frames, once the scaler has drained
   task automatic set_scale(int sw, int sh, int ow, int oh, int step);
      write_reg(bis_pkg::REG_SOURCE_WIDTH, sw);
      write_reg(bis_pkg::REG_SOURCE_HEIGHT, sh);
      write_reg(bis_pkg::REG_OUTPUT_WIDTH, ow);
      write_reg(bis_pkg::REG_OUTPUT_HEIGHT, oh);
      write_reg(bis_pkg::REG_SOURCE_STEP, step);
      hold_cycles = 64 + (ow & 16'h3FFF) + (oh & 16'h3FFF);
   endtask

   task automatic send_pixel(logic [23:0] px);
      while ($urandom_range(99) < src_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      {req_chan.in_red, req_chan.in_green, req_chan.in_blue} <= px;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      pixels_sent++;
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (hold_cycles) @(posedge clock);
   endtask

   // whole frame of random pixels; a zero width or height counts as one, like in the scaler
   task automatic send_frame(int sw, int sh);
      int n;
      n = ((sw & 12'hFFF) == 0 ? 1 : (sw & 12'hFFF)) * ((sh & 12'hFFF) == 0 ? 1 : (sh & 12'hFFF));
      for (int i = 0; i < n; i++) send_pixel($urandom());
      drain();
   endtask

   task automatic set_phase();
      if (pixels_sent < TARGET_PIX / 3) begin
         src_idle_pct = 35;
         rsp_idle_pct = 88;
      end else if (pixels_sent < 2 * TARGET_PIX / 3) begin
         src_idle_pct = 88;
         rsp_idle_pct = 35;
      end else begin
         src_idle_pct = 0;
         rsp_idle_pct = 0;
      end
   endtask

   initial begin
      int sw, sh, ow, oh, step;
      reset <= 1'b1;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      req_chan.valid <= 1'b0;
      req_chan.in_red <= '0;
      req_chan.in_green <= '0;
      req_chan.in_blue <= '0;
      stall_request = 0;
      pixels_sent = 0;
      hold_cycles = 64;
      src_idle_pct = 35;
      rsp_idle_pct = 88;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // scale four with extreme colors; the receiver holds off while pixels keep coming
      set_scale(4, 3, 16, 12, 1024);
      stall_request = 1;
      foreach (sw_list[i]) send_pixel(sw_list[i]);
      drain();
      // zero registers saturate to the smallest frame and a scale of four
      set_scale(0, 0, 0, 0, 0);
      send_frame(0, 0);
      // largest step, output smaller than the source
      set_scale(5, 2, 3, 2, 65535);
      send_frame(5, 2);
      // huge output: the last pixel of the row hits the per-pixel cap, out of range dims saturate
      set_scale(2, 1, 16383, 16383, 1024);
      send_frame(2, 1);
      // wide source row, the sample points step far past the row end
      set_scale(40, 1, 4, 1, 65535);
      send_frame(40, 1);

      while (pixels_sent < TARGET_PIX) begin
         set_phase();
         sw = $urandom_range(1, 8);
         sh = $urandom_range(1, 6);
         case ($urandom_range(3))
            0: step = 1024;
            1: step = $urandom_range(1024, 4096);
            2: step = $urandom_range(4096, 16384);
            default: step = $urandom_range(0, 65535);
         endcase
         ow = $urandom_range(1, sw * 4 + 2);
         oh = $urandom_range(1, sh * 4 + 2);
         set_scale(sw, sh, ow, oh, step);
         send_frame(sw, sh);
      end

      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
